@@ rtl/bsp_point_location_assert.svh @@
// assertion macros shared by the point location modules
`ifndef BSP_POINT_LOCATION_ASSERT_SVH
`define BSP_POINT_LOCATION_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsp_pkg.sv @@
// types and constants shared by the point location modules
package bsp_pkg;

    // mode field codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam int LINK_W  = 16;
    localparam int INDEX_W = 15;
    localparam int COUNT_W = 11;

    // one input beat
    typedef struct packed {
        logic               mode;
        logic [9:0]         node_index;
        logic signed [31:0] split_x;
        logic signed [31:0] split_y;
        logic signed [31:0] split_dx;
        logic signed [31:0] split_dy;
        logic [15:0]        front_child;
        logic [15:0]        back_child;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } in_item_t;

    // one result beat
    typedef struct packed {
        logic [14:0] leaf_index;
        logic        walk_error;
    } out_item_t;

    // one stored node
    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] ddx;
        logic [31:0] ddy;
        logic [15:0] link_front;
        logic [15:0] link_back;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_MUL,
        S_NEXT,
        S_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic write;
        logic load;
        logic check;
        logic diff;
        logic mul;
        logic next;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic leaf;
        logic bad;
    } status_t;

endpackage

@@ rtl/bsp_ram.sv @@
// generic single write port ram with registered read
module bsp_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bsp_ctrl.sv @@
// walk sequencer for the point location block
`include "bsp_point_location_assert.svh"

module bsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  bsp_pkg::status_t st,
    output bsp_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    bsp_pkg::state_t state_reg;
    bsp_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            bsp_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (mode == bsp_pkg::MODE_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = bsp_pkg::S_CHECK;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            bsp_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.leaf || st.bad)
                begin
                    state_next = bsp_pkg::S_DONE;
                end
                else
                begin
                    state_next = bsp_pkg::S_DIFF;
                end
            end
            bsp_pkg::S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = bsp_pkg::S_MUL;
            end
            bsp_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = bsp_pkg::S_NEXT;
            end
            bsp_pkg::S_NEXT:
            begin
                cmd.next   = 1'b1;
                state_next = bsp_pkg::S_CHECK;
            end
            bsp_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = bsp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bsp_pkg::S_IDLE;
            end
        endcase
    end

    // a query beat always starts with a link check
    `BSP_ASSERT_NEXT(a_query_to_check, start && !busy && mode == bsp_pkg::MODE_QUERY, state_reg == bsp_pkg::S_CHECK, "query accept did not enter check")
    // the result strobe lasts one cycle
    `BSP_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")

endmodule

@@ rtl/bsp_dpath.sv @@
// node table, side test and walk registers
`include "bsp_point_location_assert.svh"

module bsp_dpath #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bsp_pkg::COUNT_W-1:0]          cfg_data,
    input  bsp_pkg::in_item_t                    cmd_in,
    input  bsp_pkg::cmd_t                        cmd,
    output bsp_pkg::status_t                     st,
    output bsp_pkg::out_item_t                   res
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [bsp_pkg::COUNT_W-1:0] node_count_reg;
    logic [CW-1:0]               eff_reg;
    logic [CW-1:0]               eff_next;
    logic [CW-1:0]               steps_reg;
    logic [bsp_pkg::LINK_W-1:0]  link_reg;
    logic [bsp_pkg::LINK_W-1:0]  link_next;
    logic [31:0]                 px_reg;
    logic [31:0]                 py_reg;
    logic [31:0]                 rx_reg;
    logic [31:0]                 ry_reg;
    logic [31:0]                 rx_next;
    logic [31:0]                 ry_next;
    logic                        fast_reg;
    logic                        fast_next;
    logic                        side_fast_reg;
    logic                        side_fast_next;
    logic signed [47:0]          prod_l_reg;
    logic signed [47:0]          prod_r_reg;
    logic signed [47:0]          prod_l_next;
    logic signed [47:0]          prod_r_next;
    logic                        side;
    bsp_pkg::out_item_t          res_reg;
    logic [bsp_pkg::INDEX_W-1:0] idx;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_waddr;
    logic [bsp_pkg::NODE_W-1:0]  ram_rdata;
    bsp_pkg::node_t              wnode;
    bsp_pkg::node_t              node;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // node count clamped to capacity
    always_comb
    begin
        if (16'(node_count_reg) > 16'(MAX_NODES))
        begin
            eff_next = CW'(MAX_NODES);
        end
        else
        begin
            eff_next = CW'(node_count_reg);
        end
    end

    // link status
    assign idx     = link_reg[bsp_pkg::INDEX_W-1:0];
    assign st.leaf = link_reg[bsp_pkg::LINK_W-1];
    assign st.bad  = (16'(idx) >= 16'(eff_reg)) || (steps_reg >= eff_reg);

    // table write and read
    assign ram_we    = cmd.write && (16'(cmd_in.node_index) < 16'(MAX_NODES));
    assign ram_waddr = AW'(cmd_in.node_index);
    assign ram_re    = cmd.check && !st.leaf && !st.bad;

    always_comb
    begin
        wnode.ox         = cmd_in.split_x;
        wnode.oy         = cmd_in.split_y;
        wnode.ddx        = cmd_in.split_dx;
        wnode.ddy        = cmd_in.split_dy;
        wnode.link_front = cmd_in.front_child;
        wnode.link_back  = cmd_in.back_child;
    end

    bsp_ram #(
        .WIDTH (bsp_pkg::NODE_W),
        .DEPTH (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wnode),
        .re    (ram_re),
        .raddr (AW'(idx)),
        .rdata (ram_rdata)
    );

    assign node = bsp_pkg::node_t'(ram_rdata);

    // offsets and shortcut sides
    always_comb
    begin
        rx_next        = px_reg - node.ox;
        ry_next        = py_reg - node.oy;
        fast_next      = 1'b1;
        side_fast_next = 1'b0;
        priority if (node.ddx == '0)
        begin
            if ($signed(px_reg) <= $signed(node.ox))
            begin
                side_fast_next = !node.ddy[31] && (node.ddy != '0);
            end
            else
            begin
                side_fast_next = node.ddy[31];
            end
        end
        else if (node.ddy == '0)
        begin
            if ($signed(py_reg) <= $signed(node.oy))
            begin
                side_fast_next = node.ddx[31];
            end
            else
            begin
                side_fast_next = !node.ddx[31];
            end
        end
        else if (node.ddy[31] ^ node.ddx[31] ^ rx_next[31] ^ ry_next[31])
        begin
            side_fast_next = node.ddy[31] ^ rx_next[31];
        end
        else
        begin
            fast_next = 1'b0;
        end
    end

    // cross products of the offsets with the integer part of the direction
    assign prod_l_next = $signed(ry_reg) * $signed(node.ddx[31:16]);
    assign prod_r_next = $signed(node.ddy[31:16]) * $signed(rx_reg);

    // side pick and next link
    assign side = fast_reg ? side_fast_reg
                           : ($signed(prod_l_reg[47:16]) >= $signed(prod_r_reg[47:16]));

    always_comb
    begin
        link_next = link_reg;
        if (cmd.load)
        begin
            if (eff_next == '0)
            begin
                link_next = {1'b1, {bsp_pkg::INDEX_W{1'b0}}};
            end
            else
            begin
                link_next = {1'b0, bsp_pkg::INDEX_W'(eff_next - 1'b1)};
            end
        end
        else if (cmd.next)
        begin
            link_next = side ? node.link_back : node.link_front;
        end
    end

    // walk control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg   <= '0;
            steps_reg <= '0;
            link_reg  <= '0;
        end
        else
        begin
            link_reg <= link_next;
            if (cmd.load)
            begin
                eff_reg   <= eff_next;
                steps_reg <= '0;
            end
            else if (ram_re)
            begin
                steps_reg <= steps_reg + 1'b1;
            end
        end
    end

    // point, offsets and products
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= cmd_in.point_x;
            py_reg <= cmd_in.point_y;
        end
        if (cmd.diff)
        begin
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            fast_reg      <= fast_next;
            side_fast_reg <= side_fast_next;
        end
        if (cmd.mul)
        begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.check && st.leaf)
        begin
            res_reg.leaf_index <= idx;
            res_reg.walk_error <= 1'b0;
        end
        else if (cmd.check && st.bad)
        begin
            res_reg.leaf_index <= '0;
            res_reg.walk_error <= 1'b1;
        end
    end

    assign res = res_reg;

    // the step count never passes the clamped node count
    `BSP_ASSERT_SAME(a_steps_bound, 1'b1, 16'(steps_reg) <= 16'(eff_reg), "walk steps exceed node count")
    // a table read only targets a loaded node
    `BSP_ASSERT_SAME(a_read_in_range, ram_re, 16'(idx) < 16'(eff_reg) && 16'(eff_reg) <= 16'(MAX_NODES), "table read outside loaded nodes")

endmodule

@@ rtl/bsp_point_location.sv @@
// top level of the tree point location block
//
// Usage:
//   One input channel with start and busy: a beat is taken at a clock edge
//   where start is high and busy is low. Mode write stores one node entry at
//   the accepting edge and gives no result; busy stays low. Mode query walks
//   the tree from the root (node_count-1, node_count capped at MAX_NODES)
//   and gives one result beat. A result is on rsp for exactly one cycle,
//   marked by done; the receiver cannot stall, so it must take the beat in
//   that cycle. node_count is written through cfg_we and cfg_data; the user
//   must do so only while the block is idle; the block does not enforce it.
// Walk:
//   Each visited node passes link check with table read, offset subtract,
//   multiply, and compare with link select, in that order; the table read
//   is registered and the multiply is a single stage. busy stays high from
//   a query's accept through done, so the next beat waits for the result.
// Reset:
//   rst_n clears the sequencer and node_count; the node table is not
//   cleared and must be written before it is walked.
`include "bsp_point_location_assert.svh"

module bsp_point_location #(
    parameter int MAX_NODES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bsp_pkg::in_item_t               cmd,
    output logic                            done,
    output bsp_pkg::out_item_t              rsp,
    input  logic                            cfg_we,
    input  logic [bsp_pkg::COUNT_W-1:0]     cfg_data
);

    bsp_pkg::cmd_t    ctl;
    bsp_pkg::status_t st;

    // sequencer
    bsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (cmd.mode),
        .st    (st),
        .cmd   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // table and side test
    bsp_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_in   (cmd),
        .cmd      (ctl),
        .st       (st),
        .res      (rsp)
    );

    // a failed walk always reports leaf zero
    `BSP_ASSERT_SAME(a_error_leaf_zero, done && rsp.walk_error, rsp.leaf_index == '0, "error result with nonzero leaf")

endmodule

@@ tb/bsp_point_location_tb.sv @@
// self-checking testbench for the bsp point location block
module bsp_point_location_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CAP = 1024;
    localparam int LOOP_EFF_MAX = 128;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASE_BEATS = 90;
    localparam logic [15:0] LEAF_FLAG = 16'h8000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    bsp_pkg::in_item_t           cmd = '0;
    logic                        done;
    bsp_pkg::out_item_t          rsp;
    logic                        cfg_we = 1'b0;
    logic [bsp_pkg::COUNT_W-1:0] cfg_data = '0;

    // stimulus and prediction state
    bsp_pkg::in_item_t           pending_beats[$];
    bsp_pkg::out_item_t          leaf_expected[$];
    bsp_pkg::in_item_t           node_mirror[NODE_CAP];
    logic [bsp_pkg::COUNT_W-1:0] count_mirror = '0;
    int                          gap_pct = 0;
    int                          fail_count = 0;
    int                          cycle_count = 0;
    int                          phase_slots[$];
    int                          phase_eff = 0;
    logic signed [31:0]          origin_x[NODE_CAP];
    logic signed [31:0]          origin_y[NODE_CAP];

    bsp_point_location #(.MAX_NODES(NODE_CAP)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // side test of one partition line, 1 means back
    function automatic bit back_side(logic signed [31:0] px, logic signed [31:0] py,
                                     bsp_pkg::in_item_t nd);
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [63:0] wx;
        logic signed [63:0] wy;
        logic signed [63:0] ex;
        logic signed [63:0] ey;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        if (nd.split_dx == 0)
            return (px <= nd.split_x) ? (nd.split_dy > 0) : (nd.split_dy < 0);
        if (nd.split_dy == 0)
            return (py <= nd.split_y) ? (nd.split_dx < 0) : (nd.split_dx > 0);
        rx = px - nd.split_x;
        ry = py - nd.split_y;
        // sign shortcut when the four signs disagree
        if (nd.split_dy[31] ^ nd.split_dx[31] ^ rx[31] ^ ry[31])
            return nd.split_dy[31] ^ rx[31];
        wx = rx;
        wy = ry;
        ex = nd.split_dx;
        ey = nd.split_dy;
        lhs = (wy * (ex >>> 16)) >>> 16;
        rhs = ((ey >>> 16) * wx) >>> 16;
        return lhs >= rhs;
    endfunction

    // walk from the root to a leaf
    function automatic bsp_pkg::out_item_t locate_leaf(logic signed [31:0] px,
                                                       logic signed [31:0] py);
        bsp_pkg::out_item_t res;
        int                 eff;
        int                 steps;
        logic [15:0]        link;
        bsp_pkg::in_item_t  nd;
        bit                 finished;
        res = '0;
        eff = (int'(count_mirror) > NODE_CAP) ? NODE_CAP : int'(count_mirror);
        if (eff == 0)
            return res;
        link = 16'(eff - 1);
        steps = 0;
        finished = 1'b0;
        while (!finished)
        begin
            if ((link & LEAF_FLAG) != 0)
            begin
                res.leaf_index = link[14:0];
                finished = 1'b1;
            end
            else if (int'(link[14:0]) >= eff || steps >= eff)
            begin
                res.walk_error = 1'b1;
                finished = 1'b1;
            end
            else
            begin
                steps++;
                nd = node_mirror[link[9:0]];
                link = back_side(px, py, nd) ? nd.back_child : nd.front_child;
            end
        end
        return res;
    endfunction

    // coordinate mix: zero, extremes, small values, full range
    function automatic logic signed [31:0] make_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFF;
            3, 4, 5: return 32'($urandom_range(32'h0100_0000)) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // point coordinate, often on or next to a stored origin
    function automatic logic signed [31:0] point_coord(logic signed [31:0] near);
        case ($urandom_range(3))
            0: return near;
            1: return near + 32'($urandom_range(2)) - 32'd1;
            default: return make_coord();
        endcase
    endfunction

    // beat with every field random
    function automatic bsp_pkg::in_item_t noise_item();
        bsp_pkg::in_item_t it;
        it.mode = 1'($urandom);
        it.node_index = 10'($urandom);
        it.split_x = $urandom;
        it.split_y = $urandom;
        it.split_dx = $urandom;
        it.split_dy = $urandom;
        it.front_child = 16'($urandom);
        it.back_child = 16'($urandom);
        it.point_x = $urandom;
        it.point_y = $urandom;
        return it;
    endfunction

    // child link for slot s: leaf, bad index, loop, or a lower slot
    function automatic logic [15:0] random_link(int s);
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return LEAF_FLAG | 16'($urandom_range(32'h7FFF));
        if (r < 35)
            return 16'($urandom_range(32'h7FFF, phase_eff));
        if (r < 40 && phase_eff <= LOOP_EFF_MAX)
            return 16'(phase_slots[$urandom_range(phase_slots.size() - 1)]);
        if (s == 0)
            return LEAF_FLAG | 16'($urandom_range(32'h7FFF));
        if (r < 70)
            return 16'(phase_slots[s - 1]);
        return 16'(phase_slots[$urandom_range(s - 1)]);
    endfunction

    task automatic push_write(int idx, logic signed [31:0] sx, logic signed [31:0] sy,
                              logic signed [31:0] dx, logic signed [31:0] dy,
                              logic [15:0] front, logic [15:0] back);
        bsp_pkg::in_item_t it;
        it = noise_item();
        it.mode = bsp_pkg::MODE_WRITE;
        it.node_index = 10'(idx);
        it.split_x = sx;
        it.split_y = sy;
        it.split_dx = dx;
        it.split_dy = dy;
        it.front_child = front;
        it.back_child = back;
        origin_x[idx] = sx;
        origin_y[idx] = sy;
        pending_beats.push_back(it);
    endtask

    task automatic push_query(logic signed [31:0] px, logic signed [31:0] py);
        bsp_pkg::in_item_t it;
        it = noise_item();
        it.mode = bsp_pkg::MODE_QUERY;
        it.point_x = px;
        it.point_y = py;
        pending_beats.push_back(it);
    endtask

    // random node for slot s of the current tree
    task automatic push_node(int s);
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        dx = ($urandom_range(99) < 15) ? 32'sd0 : make_coord();
        dy = ($urandom_range(99) < 15) ? 32'sd0 : make_coord();
        push_write(phase_slots[s], make_coord(), make_coord(), dx, dy,
                   random_link(s), random_link(s));
    endtask

    // wait until every beat is taken and every result is back
    task automatic settle();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || start || busy || leaf_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_node_count(int value);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= bsp_pkg::COUNT_W'(value);
        count_mirror = bsp_pkg::COUNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // driver: present beats from the pending queue, predict on accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (cmd.mode == bsp_pkg::MODE_WRITE)
                    node_mirror[cmd.node_index] = cmd;
                else
                    leaf_expected.push_back(locate_leaf(cmd.point_x, cmd.point_y));
                void'(pending_beats.pop_front());
            end
            // a beat not yet taken stays on the port
            if (start && busy)
                start <= 1'b1;
            else if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                start <= 1'b1;
                cmd <= pending_beats[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        bsp_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (leaf_expected.size() == 0)
            begin
                $display("%0t: result beat with no query waiting: leaf %0d error %0b",
                         $time, rsp.leaf_index, rsp.walk_error);
                fail_count++;
            end
            else
            begin
                want = leaf_expected.pop_front();
                if (rsp.leaf_index !== want.leaf_index)
                begin
                    $display("%0t: leaf_index expected %0d actual %0d",
                             $time, want.leaf_index, rsp.leaf_index);
                    fail_count++;
                end
                if (rsp.walk_error !== want.walk_error)
                begin
                    $display("%0t: walk_error expected %0b actual %0b",
                             $time, want.walk_error, rsp.walk_error);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int counts[12];
        bit chosen[NODE_CAP];
        int k;
        int r;
        int s;
        counts = '{1, 2, 1024, 3, 7, 2047, 40, 128, 1025, 300, 1023, 16};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table gives leaf 0
        set_node_count(0);
        push_query(32'sh7FFF_FFFF, 32'sh8000_0000);

        // vertical line, up then down, point left of, on and right of it
        set_node_count(1);
        push_write(0, 0, 32'sh1234_0000, 0, 32'sh0001_0000,
                   LEAF_FLAG | 16'h7FFF, LEAF_FLAG);
        push_query(-1, 5);
        push_query(0, 0);
        push_query(1, -7);
        push_write(0, 0, 0, 0, -32'sh0001_0000, LEAF_FLAG | 16'd1, LEAF_FLAG | 16'd2);
        push_query(-1, 3);
        push_query(5, 3);

        // horizontal line pointing left
        push_write(0, 0, 32'sh0000_0100, -32'sh0001_0000, 0,
                   LEAF_FLAG | 16'd3, LEAF_FLAG | 16'd4);
        push_query(9, 32'sh0000_0100);
        push_query(9, 32'sh0000_0101);

        // general line at the extremes of the coordinate range
        push_write(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   LEAF_FLAG | 16'd5, LEAF_FLAG | 16'd6);
        push_query(32'sh7FFF_FFFF, 32'sh8000_0000);
        push_query(0, 0);
        push_query(32'sh8000_0000, 32'sh7FFF_FFFF);

        // diagonal: point on the line and just below it
        push_write(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000,
                   LEAF_FLAG | 16'd7, LEAF_FLAG | 16'd8);
        push_query(32'sh0005_0000, 32'sh0005_0000);
        push_query(32'sh0005_0000, 32'sh0004_0000);

        // link to a node that is not loaded
        push_write(0, 0, 0, 32'sh0001_0000, 0, 16'd1, 16'h7FFF);
        push_query(3, 3);

        // node that links to itself ends in a walk error at the step bound
        push_write(0, 0, 0, 0, 32'sh0001_0000, 16'd0, 16'd0);
        push_query(3, 3);

        // random trees, one per node count, across idle settings
        for (int p = 0; p < 12; p++)
        begin
            set_node_count(counts[p]);
            case (p % 3)
                0: gap_pct = 0;
                1: gap_pct = 65;
                default: gap_pct = 7;
            endcase
            phase_eff = (counts[p] > NODE_CAP) ? NODE_CAP : counts[p];
            phase_slots.delete();
            if (phase_eff <= 24)
            begin
                for (int i = 0; i < phase_eff; i++)
                    phase_slots.push_back(i);
            end
            else
            begin
                for (int i = 0; i < NODE_CAP; i++)
                    chosen[i] = 1'b0;
                chosen[phase_eff - 1] = 1'b1;
                k = $urandom_range(24, 6);
                repeat (k) chosen[$urandom_range(phase_eff - 2)] = 1'b1;
                for (int i = 0; i < phase_eff; i++)
                    if (chosen[i])
                        phase_slots.push_back(i);
            end
            for (int i = 0; i < phase_slots.size(); i++)
                push_node(i);

            // queries with rewrites of tree nodes and writes outside the tree
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                r = $urandom_range(99);
                if (r < 10)
                    push_node($urandom_range(phase_slots.size() - 1));
                else if (r < 15 && phase_eff < NODE_CAP)
                    pending_beats.push_back(noise_item());
                else
                begin
                    s = phase_slots[$urandom_range(phase_slots.size() - 1)];
                    push_query(point_coord(origin_x[s]), point_coord(origin_y[s]));
                end
                if (r >= 10 && r < 15 && phase_eff < NODE_CAP)
                begin
                    // keep the stray write off the live tree
                    pending_beats[$].mode = bsp_pkg::MODE_WRITE;
                    pending_beats[$].node_index = 10'($urandom_range(NODE_CAP - 1, phase_eff));
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
